/* design/swm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// shared constants, opcodes, fault codes and control structs of the
// segmented word machine core
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SEG_COUNT = 16;
    localparam int SEG_WORDS = 256;
    localparam int SEG_BITS  = $clog2(SEG_COUNT);
    localparam int OFF_BITS  = $clog2(SEG_WORDS);
    localparam int LEN_W     = OFF_BITS + 1;
    localparam int ADDR_W    = SEG_BITS + OFF_BITS;
    localparam int ID_W      = SEG_BITS + 1;
    localparam int OP_SHIFT  = 28;
    localparam int LV_SHIFT  = 25;

    localparam logic [3:0] OP_CMOV  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_STORE = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_NAND  = 4'd6;
    localparam logic [3:0] OP_HALT  = 4'd7;
    localparam logic [3:0] OP_MAP   = 4'd8;
    localparam logic [3:0] OP_UNMAP = 4'd9;
    localparam logic [3:0] OP_OUT   = 4'd10;
    localparam logic [3:0] OP_IN    = 4'd11;
    localparam logic [3:0] OP_LOADP = 4'd12;
    localparam logic [3:0] OP_LV    = 4'd13;

    localparam logic [3:0] FLT_NONE   = 4'd0;
    localparam logic [3:0] FLT_DIV0   = 4'd1;
    localparam logic [3:0] FLT_SEG    = 4'd2;
    localparam logic [3:0] FLT_OFF    = 4'd3;
    localparam logic [3:0] FLT_MAP    = 4'd4;
    localparam logic [3:0] FLT_UNMAP  = 4'd5;
    localparam logic [3:0] FLT_OUT    = 4'd6;
    localparam logic [3:0] FLT_PC     = 4'd7;
    localparam logic [3:0] FLT_PLONG  = 4'd8;

    typedef struct packed {
        logic latch_in;
        logic start_load;
        logic fault_pc;
        logic fetch;
        logic latch_instr;
        logic cap_c;
        logic cap_b;
        logic cap_a;
        logic exec;
        logic mem_wb;
        logic mul_wb;
        logic div_step;
        logic div_wb;
        logic zero_step;
        logic copy_rd;
        logic copy_wr;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic       mode;
        logic       halted;
        logic       pc_bad;
        logic [3:0] op;
        logic       fault;
        logic       div_last;
        logic       zero_last;
        logic       copy_go;
        logic       copy_last;
        logic       res_free;
    } sts_t;

endpackage

/* design/swm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_ctrl
// sequencer: fetch, operand read, execute and the multi-cycle sweeps
// ----------------------------------------------------------------------------
module swm_ctrl import swm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_RDC   = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_RDA   = 4'd5;
    localparam logic [3:0] S_EXEC  = 4'd6;
    localparam logic [3:0] S_MEMWB = 4'd7;
    localparam logic [3:0] S_MULWB = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DIVWB = 4'd10;
    localparam logic [3:0] S_ZERO  = 4'd11;
    localparam logic [3:0] S_CPRD  = 4'd12;
    localparam logic [3:0] S_CPWR  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_START;
                end
            end
            S_START:
            begin
                if (sts.halted)
                begin
                    state_next = S_DONE;
                end
                else if (!sts.mode)
                begin
                    cmd.start_load = 1'b1;
                    state_next     = S_DONE;
                end
                else if (sts.pc_bad)
                begin
                    cmd.fault_pc = 1'b1;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.fetch  = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.latch_instr = 1'b1;
                state_next      = S_RDC;
            end
            S_RDC:
            begin
                cmd.cap_c  = 1'b1;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.cap_b  = 1'b1;
                state_next = S_RDA;
            end
            S_RDA:
            begin
                cmd.cap_a  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
                if (!sts.fault)
                begin
                    case (sts.op)
                        OP_LOAD:  state_next = S_MEMWB;
                        OP_MUL:   state_next = S_MULWB;
                        OP_DIV:   state_next = S_DIV;
                        OP_MAP:   state_next = S_ZERO;
                        OP_LOADP: state_next = sts.copy_go ? S_CPRD : S_DONE;
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_MEMWB:
            begin
                cmd.mem_wb = 1'b1;
                state_next = S_DONE;
            end
            S_MULWB:
            begin
                cmd.mul_wb = 1'b1;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_DIVWB;
            end
            S_DIVWB:
            begin
                cmd.div_wb = 1'b1;
                state_next = S_DONE;
            end
            S_ZERO:
            begin
                cmd.zero_step = 1'b1;
                if (sts.zero_last)
                    state_next = S_DONE;
            end
            S_CPRD:
            begin
                cmd.copy_rd = 1'b1;
                state_next  = S_CPWR;
            end
            S_CPWR:
            begin
                cmd.copy_wr = 1'b1;
                state_next  = sts.copy_last ? S_DONE : S_CPRD;
            end
            S_DONE:
            begin
                if (sts.res_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* design/swm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_datapath
// registers, segment store, segment table, free id queue, divider and
// the result register
// ----------------------------------------------------------------------------
module swm_datapath import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        mode,
    input  logic [31:0] program_word,
    input  logic [7:0]  in_byte,
    input  logic        in_eof,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        input_used,
    output logic        halted,
    output logic [3:0]  fault_code,
    output logic [31:0] pc_now
);

    logic                mode_reg;
    logic [31:0]         word_reg;
    logic [7:0]          byte_reg;
    logic                eof_reg;
    logic [31:0]         pc_reg;
    logic                halt_reg;
    logic [31:0]         rf_reg [8];
    logic [31:0]         instr_reg;
    logic [31:0]         ra_reg;
    logic [31:0]         rb_reg;
    logic [31:0]         rc_reg;
    logic [LEN_W-1:0]    len_reg [SEG_COUNT];
    logic [SEG_COUNT-1:0] map_reg;
    logic [SEG_BITS-1:0] fq_reg [SEG_COUNT];
    logic [SEG_BITS-1:0] head_reg;
    logic [ID_W-1:0]     fcnt_reg;
    logic [ID_W-1:0]     fresh_reg;
    logic [31:0]         mem [2**ADDR_W];
    logic [31:0]         rdata_reg;
    logic                ovalid_reg;
    logic [7:0]          obyte_reg;
    logic                iused_reg;
    logic [3:0]          fault_reg;
    logic [31:0]         mul_reg;
    logic [31:0]         rem_reg;
    logic [31:0]         quo_reg;
    logic [4:0]          dcnt_reg;
    logic [SEG_BITS-1:0] id_reg;
    logic [LEN_W-1:0]    swp_reg;
    logic [LEN_W-1:0]    cplen_reg;
    logic                res_valid_reg;
    logic                out_valid_reg;
    logic [7:0]          out_byte_reg;
    logic                input_used_reg;
    logic                halted_reg;
    logic [3:0]          fault_code_reg;
    logic [31:0]         pc_now_reg;

    logic [3:0]          op;
    logic [2:0]          fa;
    logic [2:0]          fb;
    logic [2:0]          fc;
    logic [2:0]          lva;
    logic [2:0]          rsel;
    logic [31:0]         rf_rd;
    logic [31:0]         seg_sel;
    logic [SEG_BITS-1:0] sidx;
    logic [LEN_W-1:0]    len_sel;
    logic                seg_ok;
    logic [3:0]          flt;
    logic [SEG_BITS-1:0] new_id;
    logic [SEG_BITS-1:0] tail;
    logic                len0_full;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [31:0]         wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
    logic [32:0]         rem_sh;
    logic [33:0]         diff;

    assign op   = instr_reg[31:OP_SHIFT];
    assign fa   = instr_reg[8:6];
    assign fb   = instr_reg[5:3];
    assign fc   = instr_reg[2:0];
    assign lva  = instr_reg[LV_SHIFT+2:LV_SHIFT];
    assign rsel = cmd.cap_c ? fc : (cmd.cap_b ? fb : fa);
    assign rf_rd = rf_reg[rsel];

    // segment id under test depends on the operation
    assign seg_sel = (op == OP_STORE) ? ra_reg : ((op == OP_UNMAP) ? rc_reg : rb_reg);
    assign sidx    = seg_sel[SEG_BITS-1:0];
    assign len_sel = len_reg[sidx];
    assign seg_ok  = (seg_sel[31:SEG_BITS] == '0) && map_reg[sidx];
    assign new_id  = (fcnt_reg != '0) ? fq_reg[head_reg] : fresh_reg[SEG_BITS-1:0];
    assign tail    = head_reg + fcnt_reg[SEG_BITS-1:0];
    assign len0_full = (len_reg[0] >= LEN_W'(SEG_WORDS));

    always_comb
    begin
        flt = FLT_NONE;
        case (op)
            OP_LOAD:
            begin
                if (!seg_ok)
                    flt = FLT_SEG;
                else if (rc_reg >= 32'(len_sel))
                    flt = FLT_OFF;
            end
            OP_STORE:
            begin
                if (!seg_ok)
                    flt = FLT_SEG;
                else if (rb_reg >= 32'(len_sel))
                    flt = FLT_OFF;
            end
            OP_DIV:
            begin
                if (rc_reg == '0)
                    flt = FLT_DIV0;
            end
            OP_MAP:
            begin
                if (rc_reg > 32'(SEG_WORDS) ||
                    (fcnt_reg == '0 && fresh_reg >= ID_W'(SEG_COUNT)))
                    flt = FLT_MAP;
            end
            OP_UNMAP:
            begin
                if (rc_reg == '0 || !seg_ok || fcnt_reg[ID_W-1])
                    flt = FLT_UNMAP;
            end
            OP_OUT:
            begin
                if (rc_reg[31:8] != '0)
                    flt = FLT_OUT;
            end
            OP_LOADP:
            begin
                if (!seg_ok)
                    flt = FLT_SEG;
            end
            default:
            begin
                flt = FLT_NONE;
            end
        endcase
    end

    // store write and read address selection
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.start_load && !len0_full)
        begin
            we    = 1'b1;
            waddr = {SEG_BITS'(0), len_reg[0][OFF_BITS-1:0]};
            wdata = word_reg;
        end
        else if (cmd.exec && op == OP_STORE && flt == FLT_NONE)
        begin
            we    = 1'b1;
            waddr = {ra_reg[SEG_BITS-1:0], rb_reg[OFF_BITS-1:0]};
            wdata = rc_reg;
        end
        else if (cmd.zero_step)
        begin
            we    = 1'b1;
            waddr = {id_reg, swp_reg[OFF_BITS-1:0]};
        end
        else if (cmd.copy_wr)
        begin
            we    = 1'b1;
            waddr = {SEG_BITS'(0), swp_reg[OFF_BITS-1:0]};
            wdata = rdata_reg;
        end
    end

    always_comb
    begin
        re    = 1'b0;
        raddr = '0;
        if (cmd.fetch)
        begin
            re    = 1'b1;
            raddr = {SEG_BITS'(0), pc_reg[OFF_BITS-1:0]};
        end
        else if (cmd.exec && op == OP_LOAD)
        begin
            re    = 1'b1;
            raddr = {rb_reg[SEG_BITS-1:0], rc_reg[OFF_BITS-1:0]};
        end
        else if (cmd.copy_rd)
        begin
            re    = 1'b1;
            raddr = {rb_reg[SEG_BITS-1:0], swp_reg[OFF_BITS-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // one quotient bit per step
    assign rem_sh = {rem_reg, quo_reg[31]};
    assign diff   = {1'b0, rem_sh} - {2'b00, rc_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            mode_reg <= mode;
            word_reg <= program_word;
            byte_reg <= in_byte;
            eof_reg  <= in_eof;
        end
        if (cmd.latch_instr)
            instr_reg <= rdata_reg;
        if (cmd.cap_c)
            rc_reg <= rf_rd;
        if (cmd.cap_b)
            rb_reg <= rf_rd;
        if (cmd.cap_a)
            ra_reg <= rf_rd;
        if (cmd.exec && op == OP_MUL)
            mul_reg <= rb_reg * rc_reg;
        if (cmd.exec && op == OP_DIV)
        begin
            rem_reg <= '0;
            quo_reg <= rb_reg;
        end
        else if (cmd.div_step)
        begin
            if (!diff[33])
            begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.exec && op == OP_UNMAP && flt == FLT_NONE)
            fq_reg[tail] <= rc_reg[SEG_BITS-1:0];
        if (cmd.exec && op == OP_MAP)
            id_reg <= new_id;
        if (cmd.exec && op == OP_LOADP)
            cplen_reg <= len_sel;
        if (cmd.finish)
        begin
            out_valid_reg  <= ovalid_reg;
            out_byte_reg   <= obyte_reg;
            input_used_reg <= iused_reg;
            halted_reg     <= halt_reg;
            fault_code_reg <= fault_reg;
            pc_now_reg     <= pc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= '0;
            for (int i = 0; i < SEG_COUNT; i++)
                len_reg[i] <= '0;
            map_reg       <= SEG_COUNT'(1);
            head_reg      <= '0;
            fcnt_reg      <= '0;
            fresh_reg     <= ID_W'(1);
            ovalid_reg    <= 1'b0;
            obyte_reg     <= '0;
            iused_reg     <= 1'b0;
            fault_reg     <= FLT_NONE;
            dcnt_reg      <= '0;
            swp_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                ovalid_reg <= 1'b0;
                obyte_reg  <= '0;
                iused_reg  <= 1'b0;
                fault_reg  <= FLT_NONE;
            end
            if (cmd.start_load)
            begin
                if (len0_full)
                begin
                    fault_reg <= FLT_PLONG;
                    halt_reg  <= 1'b1;
                end
                else
                begin
                    len_reg[0] <= len_reg[0] + 1'b1;
                end
            end
            if (cmd.fault_pc)
            begin
                fault_reg <= FLT_PC;
                halt_reg  <= 1'b1;
            end
            if (cmd.exec)
            begin
                if (flt != FLT_NONE)
                begin
                    fault_reg <= flt;
                    halt_reg  <= 1'b1;
                end
                else
                begin
                    if (op != OP_HALT && op != OP_LOADP)
                        pc_reg <= pc_reg + 1'b1;
                    dcnt_reg <= '0;
                    swp_reg  <= '0;
                    case (op)
                        OP_CMOV:
                        begin
                            if (rc_reg != '0)
                                rf_reg[fa] <= rb_reg;
                        end
                        OP_ADD:  rf_reg[fa] <= rb_reg + rc_reg;
                        OP_NAND: rf_reg[fa] <= ~(rb_reg & rc_reg);
                        OP_HALT: halt_reg <= 1'b1;
                        OP_MAP:
                        begin
                            if (fcnt_reg != '0)
                            begin
                                head_reg <= head_reg + 1'b1;
                                fcnt_reg <= fcnt_reg - 1'b1;
                            end
                            else
                            begin
                                fresh_reg <= fresh_reg + 1'b1;
                            end
                            len_reg[new_id] <= rc_reg[LEN_W-1:0];
                            map_reg[new_id] <= 1'b1;
                            rf_reg[fb]      <= 32'(new_id);
                        end
                        OP_UNMAP:
                        begin
                            map_reg[sidx] <= 1'b0;
                            len_reg[sidx] <= '0;
                            fcnt_reg      <= fcnt_reg + 1'b1;
                        end
                        OP_OUT:
                        begin
                            ovalid_reg <= 1'b1;
                            obyte_reg  <= rc_reg[7:0];
                        end
                        OP_IN:
                        begin
                            iused_reg  <= 1'b1;
                            rf_reg[fc] <= eof_reg ? '1 : 32'(byte_reg);
                        end
                        OP_LOADP:
                        begin
                            if (rb_reg != '0)
                                len_reg[0] <= len_sel;
                            pc_reg <= rc_reg;
                        end
                        OP_LV:
                        begin
                            rf_reg[lva] <= 32'(instr_reg[LV_SHIFT-1:0]);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            if (cmd.mem_wb)
                rf_reg[fa] <= rdata_reg;
            if (cmd.mul_wb)
                rf_reg[fa] <= mul_reg;
            if (cmd.div_wb)
                rf_reg[fa] <= quo_reg;
            if (cmd.div_step)
                dcnt_reg <= dcnt_reg + 1'b1;
            if (cmd.zero_step || cmd.copy_wr)
                swp_reg <= swp_reg + 1'b1;
            if (cmd.finish)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts           = '0;
        sts.mode      = mode_reg;
        sts.halted    = halt_reg;
        sts.pc_bad    = (pc_reg >= 32'(len_reg[0]));
        sts.op        = op;
        sts.fault     = (flt != FLT_NONE);
        sts.div_last  = (dcnt_reg == '1);
        sts.zero_last = (swp_reg[OFF_BITS-1:0] == '1);
        sts.copy_go   = (rb_reg != '0) && (len_sel != '0);
        sts.copy_last = (swp_reg == LEN_W'(cplen_reg - 1'b1));
        sts.res_free  = !res_valid_reg || !res_stall;
    end

    assign res_valid  = res_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign input_used = input_used_reg;
    assign halted     = halted_reg;
    assign fault_code = fault_code_reg;
    assign pc_now     = pc_now_reg;

endmodule

/* design/segmented_word_machine_core_top.sv */
// sequencing: divide runs one quotient bit per cycle, map zeroes one
// word of the new segment per cycle, and load program copies each word
// with one read and one write of the single store port pair
// throughput: one word at a time; the result register lets the next word in
// reset: registers, pc and segment table cleared, segment 0 mapped and empty
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_word_machine_core_top
// 32-bit segmented word machine: controller plus datapath
// ----------------------------------------------------------------------------
module segmented_word_machine_core_top import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] program_word,
    input  logic [7:0]  in_byte,
    input  logic        in_eof,
    output logic        res_valid,
    input  logic        res_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        input_used,
    output logic        halted,
    output logic [3:0]  fault_code,
    output logic [31:0] pc_now
);

    cmd_t cmd;
    sts_t sts;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    swm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .mode         (mode),
        .program_word (program_word),
        .in_byte      (in_byte),
        .in_eof       (in_eof),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .input_used   (input_used),
        .halted       (halted),
        .fault_code   (fault_code),
        .pc_now       (pc_now)
    );

endmodule

/* design/swm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// port level checks of the machine core, bound to the top level
// ----------------------------------------------------------------------------
module swm_port_checker import swm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic [31:0] program_word,
    input logic [7:0]  in_byte,
    input logic        in_eof,
    input logic        res_valid,
    input logic        res_stall,
    input logic        out_valid,
    input logic [7:0]  out_byte,
    input logic        input_used,
    input logic        halted,
    input logic [3:0]  fault_code,
    input logic [31:0] pc_now
);

    logic seen_halt_reg;

    // a halt, once delivered, sticks for every later word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_halt_reg <= 1'b0;
        else if (res_valid && !res_stall && halted)
            seen_halt_reg <= 1'b1;
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(pc_now) && $stable(fault_code))
        else $error("result dropped or changed while stalled");

    a_fault_halts: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (fault_code == FLT_NONE) || halted)
        else $error("fault reported without halt");

    a_out_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && out_valid |-> (fault_code == FLT_NONE) && !input_used)
        else $error("output byte together with fault or input");

    a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_stall && seen_halt_reg |-> halted && (fault_code == FLT_NONE)
            && !out_valid && !input_used)
        else $error("machine acted after halt");

endmodule

bind segmented_word_machine_core_top swm_port_checker u_swm_port_checker (.*);

/* dv/swm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_checker
// watches both channels of the segmented word machine, keeps its own copy of
// the machine state, predicts one result per accepted word and compares
// ----------------------------------------------------------------------------
module swm_checker import swm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        mode,
    input  logic [31:0] program_word,
    input  logic [7:0]  in_byte,
    input  logic        in_eof,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic        out_valid,
    input  logic [7:0]  out_byte,
    input  logic        input_used,
    input  logic        halted,
    input  logic [3:0]  fault_code,
    input  logic [31:0] pc_now,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic        ovalid;
        logic [7:0]  obyte;
        logic        iused;
        logic        stop;
        logic [3:0]  fault;
        logic [31:0] pc;
    } step_result_t;

    logic [31:0]  gpr [8];
    logic [31:0]  pc;
    logic [31:0]  mem [SEG_COUNT*SEG_WORDS];
    int unsigned  seg_len [SEG_COUNT];
    bit           seg_live [SEG_COUNT];
    logic [3:0]   free_ids [$];
    int unsigned  fresh_id;
    bit           stopped;
    step_result_t expected_q [$];

    task automatic reset_machine();
        for (int i = 0; i < 8; i++) gpr[i] = '0;
        for (int i = 0; i < SEG_COUNT*SEG_WORDS; i++) mem[i] = '0;
        for (int i = 0; i < SEG_COUNT; i++)
        begin
            seg_len[i]  = 0;
            seg_live[i] = (i == 0);
        end
        free_ids.delete();
        pc       = '0;
        fresh_id = 1;
        stopped  = 0;
    endtask

    function automatic bit seg_bad(logic [31:0] id);
        return (id >= SEG_COUNT) || !seg_live[id[3:0]];
    endfunction

    task automatic run_instr(input logic [31:0] ins, input logic [7:0] ib, input logic eof,
                             output logic [3:0] flt, output bit ov, output logic [7:0] ob,
                             output bit iu, output bit jumped);
        logic [3:0]  op;
        logic [3:0]  id;
        logic [31:0] ra, rb, rc;
        int          a, b, c;
        int unsigned len;
        flt = FLT_NONE;
        ov = 0;
        ob = '0;
        iu = 0;
        jumped = 0;
        op = ins[31:28];
        a = ins[8:6];
        b = ins[5:3];
        c = ins[2:0];
        ra = gpr[a];
        rb = gpr[b];
        rc = gpr[c];
        case (op)
            OP_LV:    gpr[ins[27:25]] = {7'd0, ins[24:0]};
            OP_CMOV:  if (rc != 0) gpr[a] = rb;
            OP_LOAD:
            begin
                if (seg_bad(rb)) flt = FLT_SEG;
                else if (rc >= seg_len[rb[3:0]]) flt = FLT_OFF;
                else gpr[a] = mem[{rb[3:0], rc[7:0]}];
            end
            OP_STORE:
            begin
                if (seg_bad(ra)) flt = FLT_SEG;
                else if (rb >= seg_len[ra[3:0]]) flt = FLT_OFF;
                else mem[{ra[3:0], rb[7:0]}] = rc;
            end
            OP_ADD:   gpr[a] = rb + rc;
            OP_MUL:   gpr[a] = rb * rc;
            OP_DIV:
            begin
                if (rc == 0) flt = FLT_DIV0;
                else gpr[a] = rb / rc;
            end
            OP_NAND:  gpr[a] = ~(rb & rc);
            OP_HALT:  stopped = 1;
            OP_MAP:
            begin
                if (rc > SEG_WORDS) flt = FLT_MAP;
                else if (free_ids.size() > 0) id = free_ids.pop_front();
                else if (fresh_id < SEG_COUNT)
                begin
                    id = fresh_id[3:0];
                    fresh_id++;
                end
                else flt = FLT_MAP;
                if (flt == FLT_NONE)
                begin
                    for (int i = 0; i < SEG_WORDS; i++) mem[{id, 8'(i)}] = '0;
                    seg_len[id]  = rc;
                    seg_live[id] = 1;
                    gpr[b] = {28'd0, id};
                end
            end
            OP_UNMAP:
            begin
                if (rc == 0 || seg_bad(rc) || free_ids.size() >= SEG_COUNT) flt = FLT_UNMAP;
                else
                begin
                    seg_live[rc[3:0]] = 0;
                    seg_len[rc[3:0]]  = 0;
                    free_ids.push_back(rc[3:0]);
                end
            end
            OP_OUT:
            begin
                if (rc >= 256) flt = FLT_OUT;
                else
                begin
                    ov = 1;
                    ob = rc[7:0];
                end
            end
            OP_IN:
            begin
                iu = 1;
                gpr[c] = eof ? 32'hFFFF_FFFF : {24'd0, ib};
            end
            OP_LOADP:
            begin
                if (seg_bad(rb)) flt = FLT_SEG;
                else
                begin
                    // copying segment 0 onto itself changes nothing
                    if (rb != 0)
                    begin
                        len = seg_len[rb[3:0]];
                        for (int i = 0; i < len; i++) mem[i] = mem[{rb[3:0], 8'(i)}];
                        seg_len[0] = len;
                    end
                    pc = rc;
                    jumped = 1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic predict_word(input logic m, input logic [31:0] w, input logic [7:0] ib,
                                input logic eof, output step_result_t r);
        logic [3:0] flt;
        logic [7:0] ob;
        bit         ov, iu, jumped;
        flt = FLT_NONE;
        ob = '0;
        ov = 0;
        iu = 0;
        jumped = 0;
        if (!stopped)
        begin
            if (m == 1'b0)
            begin
                if (seg_len[0] >= SEG_WORDS) flt = FLT_PLONG;
                else
                begin
                    mem[seg_len[0]] = w;
                    seg_len[0]++;
                end
            end
            else if (pc >= seg_len[0]) flt = FLT_PC;
            else
            begin
                run_instr(mem[pc[7:0]], ib, eof, flt, ov, ob, iu, jumped);
                if (flt == FLT_NONE && !stopped && !jumped) pc = pc + 1;
            end
            if (flt != FLT_NONE)
            begin
                stopped = 1;
                ov = 0;
                ob = '0;
            end
        end
        r = '{ovalid: ov, obyte: ob, iused: iu, stop: stopped, fault: flt, pc: pc};
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        step_result_t want;
        step_result_t next_r;
        if (!rst_n)
        begin
            reset_machine();
            expected_q.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_q.size() == 0) report_mismatch("unexpected result word", 0, pc_now);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_valid !== want.ovalid) report_mismatch("out_valid", want.ovalid, out_valid);
                    if (out_byte !== want.obyte) report_mismatch("out_byte", want.obyte, out_byte);
                    if (input_used !== want.iused) report_mismatch("input_used", want.iused, input_used);
                    if (halted !== want.stop) report_mismatch("halted", want.stop, halted);
                    if (fault_code !== want.fault) report_mismatch("fault_code", want.fault, fault_code);
                    if (pc_now !== want.pc) report_mismatch("pc_now", want.pc, pc_now);
                end
            end
            if (in_valid && !in_stall)
            begin
                predict_word(mode, program_word, in_byte, in_eof, next_r);
                expected_q.push_back(next_r);
            end
            pending = expected_q.size();
        end
    end

endmodule

/* dv/tb_segmented_word_machine_core_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segmented_word_machine_core_top
// builds fault-free programs in phases (load words, then step them), each
// phase ending with a program reload that recycles segment 0; the run closes
// with one randomly chosen halt or fault and a few words on the halted machine
// ----------------------------------------------------------------------------
module tb_segmented_word_machine_core_top;
    import swm_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        mode = 1'b0;
    logic [31:0] program_word = '0;
    logic [7:0]  in_byte = '0;
    logic        in_eof = 1'b0;
    logic        res_stall = 1'b0;
    logic        in_stall, res_valid, out_valid, input_used, halted;
    logic [7:0]  out_byte;
    logic [3:0]  fault_code;
    logic [31:0] pc_now;

    int          fail_count, pending, results_seen;
    logic [31:0] prog [$];
    int          seg0_len = 0;
    int          sent = 0;
    int          phases = 0;
    int          stall_left = 0;
    int          cycles = 0;
    bit          quiet = 0;
    logic [3:0]  fc;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    segmented_word_machine_core_top dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .program_word(program_word), .in_byte(in_byte), .in_eof(in_eof),
        .res_valid(res_valid), .res_stall(res_stall), .out_valid(out_valid),
        .out_byte(out_byte), .input_used(input_used), .halted(halted),
        .fault_code(fault_code), .pc_now(pc_now)
    );

    swm_checker u_check (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
        .program_word(program_word), .in_byte(in_byte), .in_eof(in_eof),
        .res_valid(res_valid), .res_stall(res_stall), .out_valid(out_valid),
        .out_byte(out_byte), .input_used(input_used), .halted(halted),
        .fault_code(fault_code), .pc_now(pc_now), .fail_count(fail_count),
        .pending(pending), .results_seen(results_seen)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("segmented_word_machine_core_top regression: fail");
            $finish;
        end
    end

    // result side stalls in bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            res_stall = 1'b1;
        end
        else if (!quiet && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 17);
            res_stall = 1'b1;
        end
        else res_stall = 1'b0;
    end

    function automatic logic [31:0] enc(logic [3:0] op, int a, int b, int c);
        logic [18:0] pad;
        pad = 19'($urandom);
        return {op, pad, 3'(a), 3'(b), 3'(c)};
    endfunction

    function automatic logic [31:0] load_imm(int r, logic [31:0] v);
        return {OP_LV, 3'(r), v[24:0]};
    endfunction

    function automatic logic [31:0] rand_imm();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'h1FF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic m, input logic [31:0] w);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid     = 1'b1;
        mode         = m;
        program_word = w;
        case ($urandom_range(0, 3))
            0: in_byte = 8'h00;
            1: in_byte = 8'hFF;
            default: in_byte = 8'($urandom);
        endcase
        in_eof = ($urandom_range(0, 7) == 0);
        do @(posedge clk); while (in_stall);
        sent++;
        if (sent >= 1100) quiet = 1;
    endtask

    // load the queued words, then step through the whole of segment 0
    task automatic load_and_step();
        int steps;
        steps = seg0_len + prog.size();
        foreach (prog[i]) send_word(1'b0, prog[i]);
        seg0_len = steps;
        repeat (steps) send_word(1'b1, $urandom);
    endtask

    // map a short segment into r5, fill its head with harmless cmov words and
    // reload it as the program so segment 0 starts over
    task automatic close_phase(output int next_len);
        next_len = $urandom_range(0, 12);
        prog.push_back(load_imm(4, next_len));
        prog.push_back(enc(OP_MAP, 0, 5, 4));
        for (int j = 0; j < next_len && j < 3; j++)
        begin
            prog.push_back(load_imm(6, j));
            prog.push_back(load_imm(7, $urandom & 32'h1FF_FE3F));
            prog.push_back(enc(OP_STORE, 5, 6, 7));
        end
        prog.push_back(load_imm(6, 0));
        prog.push_back(enc(OP_LOADP, 0, 5, 6));
    endtask

    task automatic add_snippet(input int base);
        int len, off, target;
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: prog.push_back(enc(OP_CMOV, $urandom_range(0, 2), $urandom_range(0, 7),
                                          $urandom_range(0, 7)));
                    1: prog.push_back(enc(OP_ADD, $urandom_range(0, 2), $urandom_range(0, 7),
                                          $urandom_range(0, 7)));
                    2: prog.push_back(enc(OP_MUL, $urandom_range(0, 2), $urandom_range(0, 7),
                                          $urandom_range(0, 7)));
                    default: prog.push_back(enc(OP_NAND, $urandom_range(0, 2),
                                                $urandom_range(0, 7), $urandom_range(0, 7)));
                endcase
            end
            1: prog.push_back(load_imm($urandom_range(0, 2), rand_imm()));
            2:
            begin
                v = rand_imm() & 32'h1FF_FFFF;
                if ($urandom_range(0, 1) == 0)
                begin
                    if (v == 0) v = 1;
                    prog.push_back(load_imm(7, v));
                end
                else
                begin
                    // nand of a 25-bit value with itself gives a large divisor
                    prog.push_back(load_imm(4, v));
                    prog.push_back(enc(OP_NAND, 7, 4, 4));
                end
                prog.push_back(enc(OP_DIV, $urandom_range(0, 2), $urandom_range(0, 7), 7));
            end
            3:
            begin
                prog.push_back(load_imm(7, $urandom_range(0, 1) ? $urandom_range(0, 255)
                                                                : 255 * $urandom_range(0, 1)));
                prog.push_back(enc(OP_OUT, 0, 0, 7));
            end
            4: prog.push_back(enc(OP_IN, 0, 0, $urandom_range(0, 2)));
            5:
            begin
                len = ($urandom_range(0, 5) == 0) ? SEG_WORDS : $urandom_range(1, 16);
                case ($urandom_range(0, 3))
                    0: off = 0;
                    1: off = len - 1;
                    default: off = $urandom_range(0, len - 1);
                endcase
                prog.push_back(load_imm(4, len));
                prog.push_back(enc(OP_MAP, 0, 6, 4));
                prog.push_back(load_imm(7, off));
                prog.push_back(enc(OP_STORE, 6, 7, $urandom_range(0, 2)));
                prog.push_back(enc(OP_LOAD, $urandom_range(0, 2), 6, 7));
                prog.push_back(enc(OP_UNMAP, 0, 0, 6));
            end
            6: prog.push_back({4'(14 + $urandom_range(0, 1)), 28'($urandom)});
            7:
            begin
                // read back a word of the running program
                off = $urandom_range(0, base + prog.size() - 1);
                prog.push_back(load_imm(4, 0));
                prog.push_back(load_imm(7, off));
                prog.push_back(enc(OP_LOAD, $urandom_range(0, 2), 4, 7));
            end
            8:
            begin
                // reload of segment 0 itself acts as a jump to the next word
                target = base + prog.size() + 3;
                prog.push_back(load_imm(2, 0));
                prog.push_back(load_imm(6, target));
                prog.push_back(enc(OP_LOADP, 0, 2, 6));
            end
            default:
            begin
                len = ($urandom_range(0, 7) == 0) ? SEG_WORDS : $urandom_range(0, 16);
                prog.push_back(load_imm(4, len));
                prog.push_back(enc(OP_MAP, 0, 6, 4));
                prog.push_back(enc(OP_MAP, 0, 7, 4));
                if ($urandom_range(0, 1))
                begin
                    prog.push_back(enc(OP_UNMAP, 0, 0, 6));
                    prog.push_back(enc(OP_UNMAP, 0, 0, 7));
                end
                else
                begin
                    prog.push_back(enc(OP_UNMAP, 0, 0, 7));
                    prog.push_back(enc(OP_UNMAP, 0, 0, 6));
                end
            end
        endcase
    endtask

    task automatic closing_scenario();
        int limit_len;
        prog.delete();
        case (fc)
            FLT_DIV0:
            begin
                prog.push_back(load_imm(7, 0));
                prog.push_back(enc(OP_DIV, 0, 0, 7));
            end
            FLT_SEG:
            begin
                prog.push_back(load_imm(7, $urandom_range(0, 1) ? 15 : $urandom_range(16, 32'h1FF_FFFF)));
                prog.push_back(enc(OP_LOAD, 0, 7, 7));
            end
            FLT_OFF:
            begin
                prog.push_back(load_imm(4, 0));
                prog.push_back(load_imm(7, $urandom | 32'h100));
                prog.push_back(enc(OP_LOAD, 0, 4, 7));
            end
            FLT_MAP:
            begin
                if ($urandom_range(0, 1))
                begin
                    prog.push_back(load_imm(4, $urandom_range(SEG_WORDS + 1, 32'h1FF_FFFF)));
                    prog.push_back(enc(OP_MAP, 0, 6, 4));
                end
                else
                begin
                    // run the id pool dry
                    prog.push_back(load_imm(4, 0));
                    repeat (SEG_COUNT) prog.push_back(enc(OP_MAP, 0, 6, 4));
                end
            end
            FLT_UNMAP:
            begin
                case ($urandom_range(0, 2))
                    0: prog.push_back(load_imm(7, 0));
                    1: prog.push_back(load_imm(7, 14));
                    default: prog.push_back(load_imm(7, $urandom_range(16, 32'h1FF_FFFF)));
                endcase
                prog.push_back(enc(OP_UNMAP, 0, 0, 7));
            end
            FLT_OUT:
            begin
                prog.push_back(load_imm(7, $urandom_range(256, 32'h1FF_FFFF)));
                prog.push_back(enc(OP_OUT, 0, 0, 7));
            end
            FLT_PC:
            begin
                prog.push_back(load_imm(2, 0));
                prog.push_back(load_imm(6, $urandom_range(300, 32'h1FF_FFFF)));
                prog.push_back(enc(OP_LOADP, 0, 2, 6));
            end
            FLT_PLONG:
            begin
                limit_len = SEG_WORDS - seg0_len + 1;
                repeat (limit_len) prog.push_back({4'd14, 28'($urandom)});
            end
            default: prog.push_back(enc(OP_HALT, 0, 0, 0));
        endcase
        if (fc == FLT_PLONG) foreach (prog[i]) send_word(1'b0, prog[i]);
        else load_and_step();
        if (fc == FLT_PC) send_word(1'b1, $urandom);
        repeat (12) send_word(1'($urandom_range(0, 1)), $urandom);
    endtask

    initial
    begin : stimulus
        int next_len, target_len;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed opening: every operation except halt, and the word extremes
        prog.push_back(load_imm(0, 32'h1FF_FFFF));
        prog.push_back(load_imm(1, 0));
        prog.push_back(enc(OP_NAND, 2, 1, 1));
        prog.push_back(enc(OP_ADD, 0, 2, 2));
        prog.push_back(enc(OP_MUL, 1, 2, 2));
        prog.push_back(enc(OP_CMOV, 0, 2, 1));
        prog.push_back(load_imm(7, 0));
        prog.push_back(enc(OP_CMOV, 0, 2, 7));
        prog.push_back(enc(OP_DIV, 0, 2, 0));
        prog.push_back(enc(OP_OUT, 0, 0, 7));
        prog.push_back(load_imm(7, 255));
        prog.push_back(enc(OP_OUT, 0, 0, 7));
        prog.push_back(enc(OP_IN, 0, 0, 1));
        prog.push_back(32'hFFFF_FFFF);
        prog.push_back(32'h0000_0000);
        prog.push_back(32'hE000_0000);
        prog.push_back(load_imm(4, SEG_WORDS));
        prog.push_back(enc(OP_MAP, 0, 6, 4));
        prog.push_back(enc(OP_STORE, 6, 7, 2));
        prog.push_back(enc(OP_LOAD, 1, 6, 7));
        prog.push_back(enc(OP_UNMAP, 0, 0, 6));
        close_phase(next_len);
        load_and_step();
        seg0_len = next_len;
        phases++;

        while (sent < 1250)
        begin
            prog.delete();
            prog.push_back(enc(OP_UNMAP, 0, 0, 5));
            target_len = $urandom_range(40, 200);
            while (seg0_len + prog.size() < target_len) add_snippet(seg0_len);
            close_phase(next_len);
            load_and_step();
            seg0_len = next_len;
            phases++;
            if (phases == 3)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                while (pending != 0) @(negedge clk);
            end
        end

        fc = 4'($urandom_range(0, 8));
        closing_scenario();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (600) @(negedge clk);

        $display("%0d words sent over %0d program phases, %0d results checked",
                 sent, phases, results_seen);
        $display("closing scenario ended the machine with fault code %0d", fc);
        if (fail_count == 0 && pending == 0)
            $display("segmented_word_machine_core_top regression: pass");
        else
            $display("segmented_word_machine_core_top regression: fail");
        $finish;
    end

endmodule

/* segmented_word_machine_core_top.f */
design/swm_pkg.sv
design/swm_ctrl.sv
design/swm_datapath.sv
design/segmented_word_machine_core_top.sv
design/swm_checker.sv
dv/swm_checker.sv
dv/tb_segmented_word_machine_core_top.sv
